FILE: src/ssmf_pkg.sv
// ----------------------------------------------------------------------------
// ssmf_pkg - shared types and constants of the sensor sample filter
// Stream field widths, register indexes, channel codes, controller states,
// conversion gains and the fixed-point constants used by the converter.
// ----------------------------------------------------------------------------
package ssmf_pkg;

	// stream and register port widths
	localparam int IN_DATA_W   = 16;
	localparam int IN_USER_W   = 3;
	localparam int OUT_DATA_W  = 24;
	localparam int OUT_USER_W  = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// converted value and input sample widths
	localparam int VAL_W       = 24;
	localparam int SAMPLE_W    = 13;

	// conversion gains, Q16
	localparam int PH_GAIN_Q16   = 293;
	localparam int TDS_GAIN_Q16  = 26214;
	localparam int TURB_GAIN_Q16 = 52429;

	// Q8 constants
	localparam int TURB_MAX_Q8     = 768000;
	localparam int Q8_PH_SEVEN     = 1792;
	localparam int Q8_PH_MAX       = 3584;
	localparam int Q8_TEMP_DEFAULT = 6400;
	localparam int VAL24_MAX       = 8388607;
	localparam int VAL24_MIN       = -8388608;

	typedef enum logic [1:0] {
		CH_PH   = 2'd0,
		CH_TDS  = 2'd1,
		CH_TEMP = 2'd2,
		CH_TURB = 2'd3
	} chan_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEDIAN_MODE  = 3'd0,
		REG_PH_NEUTRAL   = 3'd1,
		REG_TURB_CLEAR   = 3'd2,
		REG_PH_OFFSET    = 3'd3,
		REG_TDS_OFFSET   = 3'd4,
		REG_TEMP_OFFSET  = 3'd5,
		REG_TURB_OFFSET  = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CONV,
		ST_INS,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               median_mode;
		logic        [11:0] ph_neutral_count;
		logic        [11:0] turb_clear_count;
		logic signed [15:0] ph_offset;
		logic signed [15:0] tds_offset;
		logic signed [15:0] temp_offset;
		logic signed [15:0] turb_offset;
	} cfg_t;

	typedef struct packed {
		logic insert;
		logic occupied;
	} cell_ctl_t;

endpackage

FILE: src/ssmf_convert.sv
// ----------------------------------------------------------------------------
// ssmf_convert - sample to signed Q8 conversion
// Two stages: one shared multiplier for the gain, then floor shift, clamp,
// offset add and saturation to the 24-bit value range.
// ----------------------------------------------------------------------------
module ssmf_convert (
	input  logic                                clk,
	input  logic                                en_mul,
	input  logic                                en_conv,
	input  logic [1:0]                          channel,
	input  logic signed [ssmf_pkg::SAMPLE_W-1:0] sample,
	input  logic                                sensor_missing,
	input  ssmf_pkg::cfg_t                      cfg,
	output logic signed [ssmf_pkg::VAL_W-1:0]    conv_val
);
	import ssmf_pkg::*;

	localparam logic signed [29:0] PH_SEVEN  = 30'(Q8_PH_SEVEN);
	localparam logic signed [29:0] PH_MAX    = 30'(Q8_PH_MAX);
	localparam logic signed [29:0] TEMP_DEF  = 30'(Q8_TEMP_DEFAULT);
	localparam logic signed [29:0] TURB_MAX  = 30'(TURB_MAX_Q8);
	localparam logic signed [29:0] SAT_MAX   = 30'(VAL24_MAX);
	localparam logic signed [29:0] SAT_MIN   = 30'(VAL24_MIN);

	logic signed [13:0]        mul_a;
	logic signed [21:0]        mul_b;
	logic signed [35:0]        prod_s1;
	logic signed [27:0]        p8;
	logic signed [29:0]        p8_w;
	logic signed [29:0]        ph_pre;
	logic signed [29:0]        pre;
	logic signed [29:0]        offs;
	logic signed [29:0]        wide;
	logic signed [VAL_W-1:0]   sat;
	logic signed [VAL_W-1:0]   conv_s2;

	// multiplier operands per channel
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (chan_t'(channel))
			CH_PH: begin
				mul_a = signed'({2'b00, cfg.ph_neutral_count}) - 14'(sample);
				mul_b = 22'(PH_GAIN_Q16);
			end
			CH_TDS: begin
				mul_a = 14'(sample);
				mul_b = 22'(TDS_GAIN_Q16);
			end
			CH_TURB: begin
				mul_a = signed'({2'b00, cfg.turb_clear_count}) - 14'(sample);
				mul_b = 22'(TURB_GAIN_Q16);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// gain product
	always_ff @(posedge clk) begin
		if (en_mul) begin
			prod_s1 <= mul_a * mul_b;
		end
	end

	// floor divide by 256, clamp and offset
	assign p8     = signed'(prod_s1[35:8]);
	assign p8_w   = 30'(p8);
	assign ph_pre = p8_w + PH_SEVEN;

	always_comb begin
		pre  = '0;
		offs = '0;
		case (chan_t'(channel))
			CH_PH: begin
				if (ph_pre < 30'sd0) begin
					pre = '0;
				end else if (ph_pre > PH_MAX) begin
					pre = PH_MAX;
				end else begin
					pre = ph_pre;
				end
				offs = 30'(signed'(cfg.ph_offset));
			end
			CH_TDS: begin
				pre  = p8_w;
				offs = 30'(signed'(cfg.tds_offset));
			end
			CH_TEMP: begin
				pre  = sensor_missing ? TEMP_DEF : 30'(sample) * 30'sd16;
				offs = 30'(signed'(cfg.temp_offset));
			end
			default: begin
				if (p8_w < 30'sd0) begin
					pre = '0;
				end else if (p8_w > TURB_MAX) begin
					pre = TURB_MAX;
				end else begin
					pre = p8_w;
				end
				offs = 30'(signed'(cfg.turb_offset));
			end
		endcase
		wide = pre + offs;
	end

	// saturate to the 24-bit range
	always_comb begin
		if (wide > SAT_MAX) begin
			sat = VAL_W'(SAT_MAX);
		end else if (wide < SAT_MIN) begin
			sat = VAL_W'(SAT_MIN);
		end else begin
			sat = wide[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_conv) begin
			conv_s2 <= sat;
		end
	end

	assign conv_val = conv_s2;

endmodule

FILE: src/ssmf_cell.sv
// ----------------------------------------------------------------------------
// ssmf_cell - one cell of the insertion sorting row
// Holds one value of the group in ascending order; on insert it either keeps
// its value, takes the new value or takes the value of its left neighbour.
// ----------------------------------------------------------------------------
module ssmf_cell (
	input  logic                              clk,
	input  ssmf_pkg::cell_ctl_t               ctl,
	input  logic signed [ssmf_pkg::VAL_W-1:0] new_val,
	input  logic signed [ssmf_pkg::VAL_W-1:0] left_val,
	input  logic                              left_lt,
	output logic                              lt,
	output logic signed [ssmf_pkg::VAL_W-1:0] val
);
	import ssmf_pkg::*;

	logic signed [VAL_W-1:0] val_q;

	// an empty cell counts as larger than anything
	assign lt = !ctl.occupied || (new_val < val_q);

	// shift right from the insertion point onwards
	always_ff @(posedge clk) begin
		if (ctl.insert && lt) begin
			val_q <= left_lt ? left_val : new_val;
		end
	end

	assign val = val_q;

endmodule

FILE: src/ssmf_mean.sv
// ----------------------------------------------------------------------------
// ssmf_mean - group sum divided by the group size
// Magnitude times a 32-bit reciprocal, then one compare and add to correct
// the quotient; the sign is put back so the result truncates toward zero.
// ----------------------------------------------------------------------------
module ssmf_mean #(
	parameter int GROUP_SIZE = 3,
	parameter int SUM_W      = 27
) (
	input  logic                              clk,
	input  logic                              start,
	input  logic signed [SUM_W-1:0]           sum,
	output logic signed [ssmf_pkg::VAL_W-1:0] mean
);
	import ssmf_pkg::*;

	localparam logic [31:0]      RECIP   = 32'(64'hFFFF_FFFF / GROUP_SIZE);
	localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(GROUP_SIZE);

	logic [SUM_W-1:0]    mag;
	logic [SUM_W-1:0]    mag_s1;
	logic                neg_s1;
	logic [SUM_W+31:0]   prod_s1;
	logic [SUM_W-1:0]    q0;
	logic [SUM_W-1:0]    rem;
	logic [SUM_W-1:0]    quo;
	logic [SUM_W-1:0]    sq;

	assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

	// reciprocal product
	always_ff @(posedge clk) begin
		if (start) begin
			neg_s1  <= sum[SUM_W-1];
			mag_s1  <= mag;
			prod_s1 <= (SUM_W+32)'(mag) * (SUM_W+32)'(RECIP);
		end
	end

	// estimate is at most one short
	assign q0   = prod_s1[SUM_W+31:32];
	assign rem  = mag_s1 - q0 * DIVISOR;
	assign quo  = q0 + SUM_W'(rem >= DIVISOR);
	assign sq   = neg_s1 ? (~quo + SUM_W'(1)) : quo;
	assign mean = signed'(sq[VAL_W-1:0]);

endmodule

FILE: src/sensor_sample_median_mean_filter.sv
// ----------------------------------------------------------------------------
// sensor_sample_median_mean_filter - median or mean of a group of samples
// Converts each sensor sample to signed Q8, keeps the group sorted in a row
// of cells and a running sum, and emits the median or the mean per group.
// ----------------------------------------------------------------------------
//  channel   dir   signals                         content
//  s_*       in    s_tvalid s_tready s_tdata s_tuser  one sensor sample
//  m_*       out   m_tvalid m_tready m_tdata m_tuser  one result per group
//  cfg_*     in    cfg_we cfg_addr cfg_wdata          register writes
//
//  a sample passes accept, gain multiply, convert and insert into the
//  cell row; the sample that closes a group then also passes the reciprocal
//  multiply of the mean and the load of the output register
//  the output register frees the input side: samples are taken while a
//  result waits, a closing sample holds only until the output is free
//  arst_n clears control state and the registers; the cell row needs no
//  clearing as the fill count marks which cells hold data
// ----------------------------------------------------------------------------
module sensor_sample_median_mean_filter #(
	parameter int GROUP_SIZE = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sample [12:0], zero filled
	input  logic [ssmf_pkg::IN_DATA_W-1:0]      s_tdata,
	// channel [1:0], sensor_missing [2]
	input  logic [ssmf_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// filtered_value [23:0]
	output logic [ssmf_pkg::OUT_DATA_W-1:0]     m_tdata,
	// result_channel [1:0], fallback_used [2]
	output logic [ssmf_pkg::OUT_USER_W-1:0]     m_tuser,
	input  logic                                cfg_we,
	input  logic [ssmf_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [ssmf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import ssmf_pkg::*;

	localparam int CNT_W = $clog2(GROUP_SIZE + 1);
	localparam int SUM_W = VAL_W + $clog2(GROUP_SIZE) + 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GROUP_SIZE - 1);

	state_t                  state_q;
	state_t                  state_d;
	cfg_t                    cfg_q;
	logic                    s_accept;
	logic                    en_mul;
	logic                    en_conv;
	logic                    do_ins;
	logic                    div_start;
	logic                    emit_load;
	logic                    complete;

	logic [1:0]              ch_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                    missing_q;
	logic                    fallback_q;
	logic [CNT_W-1:0]        count_q;
	logic                    group_fb_q;
	logic [1:0]              res_ch_q;
	logic signed [SUM_W-1:0] sum_q;

	logic signed [VAL_W-1:0] conv_val;
	logic signed [VAL_W-1:0] mean_val;
	logic signed [VAL_W-1:0] cell_val [GROUP_SIZE];
	logic                    cell_lt  [GROUP_SIZE];

	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_data_q;
	logic [OUT_USER_W-1:0]   m_user_q;

	assign s_accept = s_tvalid && s_tready;
	assign complete = (count_q == LAST_CNT);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.median_mode      <= 1'b0;
			cfg_q.ph_neutral_count <= 12'd2048;
			cfg_q.turb_clear_count <= 12'd3000;
			cfg_q.ph_offset        <= '0;
			cfg_q.tds_offset       <= '0;
			cfg_q.temp_offset      <= '0;
			cfg_q.turb_offset      <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_MEDIAN_MODE: cfg_q.median_mode      <= cfg_wdata[0];
				REG_PH_NEUTRAL:  cfg_q.ph_neutral_count <= cfg_wdata[11:0];
				REG_TURB_CLEAR:  cfg_q.turb_clear_count <= cfg_wdata[11:0];
				REG_PH_OFFSET:   cfg_q.ph_offset        <= signed'(cfg_wdata);
				REG_TDS_OFFSET:  cfg_q.tds_offset       <= signed'(cfg_wdata);
				REG_TEMP_OFFSET: cfg_q.temp_offset      <= signed'(cfg_wdata);
				REG_TURB_OFFSET: cfg_q.turb_offset      <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) begin
				state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_CONV;
			ST_CONV: state_d = ST_INS;
			ST_INS:  state_d = complete ? ST_DIV : ST_IDLE;
			ST_DIV:  state_d = ST_EMIT;
			ST_EMIT: if (!m_tvalid_q || m_tready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		en_mul    = (state_q == ST_MUL);
		en_conv   = (state_q == ST_CONV);
		do_ins    = (state_q == ST_INS);
		div_start = (state_q == ST_DIV);
		emit_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			ch_q      <= s_tuser[1:0];
			sample_q  <= signed'(s_tdata[SAMPLE_W-1:0]);
			missing_q <= s_tuser[2];
		end
	end

	// group bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= 1'b0;
			count_q    <= '0;
			group_fb_q <= 1'b0;
			res_ch_q   <= '0;
			sum_q      <= '0;
		end else begin
			if (s_accept && (chan_t'(s_tuser[1:0]) == CH_TEMP) && s_tuser[2]) begin
				fallback_q <= 1'b1;
			end
			if (do_ins) begin
				sum_q <= ((count_q == '0) ? SUM_W'(0) : sum_q) + SUM_W'(conv_val);
				if (complete) begin
					count_q    <= '0;
					group_fb_q <= fallback_q;
					res_ch_q   <= ch_q;
					fallback_q <= 1'b0;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	ssmf_convert u_convert (
		.clk            (clk),
		.en_mul         (en_mul),
		.en_conv        (en_conv),
		.channel        (ch_q),
		.sample         (sample_q),
		.sensor_missing (missing_q),
		.cfg            (cfg_q),
		.conv_val       (conv_val)
	);

	// sorting row
	for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.insert   = do_ins;
		assign ctl.occupied = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_first
			ssmf_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.new_val  (conv_val),
				.left_val (conv_val),
				.left_lt  (1'b0),
				.lt       (cell_lt[i]),
				.val      (cell_val[i])
			);
		end else begin : g_next
			ssmf_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.new_val  (conv_val),
				.left_val (cell_val[i-1]),
				.left_lt  (cell_lt[i-1]),
				.lt       (cell_lt[i]),
				.val      (cell_val[i])
			);
		end
	end

	ssmf_mean #(
		.GROUP_SIZE (GROUP_SIZE),
		.SUM_W      (SUM_W)
	) u_mean (
		.clk   (clk),
		.start (div_start),
		.sum   (sum_q),
		.mean  (mean_val)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			m_data_q <= cfg_q.median_mode ? cell_val[GROUP_SIZE/2] : mean_val;
			m_user_q <= {group_fb_q, res_ch_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

FILE: src/ssmf_checker.sv
// ----------------------------------------------------------------------------
// ssmf_checker - port level checks of the sensor sample filter
// Watches the stream ports for busy spacing, output hold and result timing.
// ----------------------------------------------------------------------------
module ssmf_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [ssmf_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [ssmf_pkg::OUT_USER_W-1:0] m_tuser
);
	import ssmf_pkg::*;

	logic s_accept;
	assign s_accept = s_tvalid && s_tready;

	// a request keeps the block busy through conversion and insertion
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken again during conversion");

	// ready only drops on a request
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input ready dropped without a request");

	// a result never follows a request within the conversion latency
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_accept, 1) && !$past(s_accept, 2) &&
			!$past(s_accept, 3) && !$past(s_accept, 4) && !$past(s_accept, 5))
		else $error("result appeared too soon after a request");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind sensor_sample_median_mean_filter ssmf_checker u_ssmf_checker (.*);
